/* sv/pip_pkg.sv */
// Shared constants, codes and controller/datapath handshake types for the polygon test.
package pip_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = 6;
  localparam int VIDX_W       = 5;
  localparam int LAT_W        = 15;
  localparam int LON_W        = 16;
  localparam int DLAT_W       = LAT_W + 1;
  localparam int DLON_W       = LON_W + 1;
  localparam int NUM_W        = DLAT_W + DLON_W;
  localparam int QUO_W        = DLAT_W;
  localparam int REM_W        = DLON_W;
  localparam int STEP_W       = $clog2(QUO_W);
  localparam int CMPW         = LAT_W + 3;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_TEST  = 1'b1
  } pip_op_e;

  typedef struct packed {
    logic             wr;
    logic             load_pt;
    logic             load_j;
    logic             load_i;
    logic             mul;
    logic             prep;
    logic             div_step;
    logic             cmp;
    logic             shift;
    logic             publish;
    logic [IDX_W-1:0] raddr;
  } pip_cmd_t;

  typedef struct packed {
    logic straddle;
  } pip_sts_t;

endpackage

/* sv/pip_in_if.sv */
// Input channel carrying one command word with its vertex or test point.
interface pip_in_if import pip_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [VIDX_W-1:0]       vertex_index;
  logic signed [LAT_W-1:0] point_lat;
  logic signed [LON_W-1:0] point_lon;

  modport source (output valid, command, vertex_index, point_lat, point_lon, input ready);
  modport sink   (input valid, command, vertex_index, point_lat, point_lon, output ready);
endinterface

/* sv/pip_out_if.sv */
// Output channel carrying one inside/outside result word.
interface pip_out_if import pip_pkg::*; ();
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

/* sv/pip_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module pip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/pip_dp.sv */
// Datapath: vertex table, edge registers, multiplier, serial divider and crossing parity.
module pip_dp import pip_pkg::*; (
  input  logic                    clk_i,
  input  pip_cmd_t                cmd_i,
  output pip_sts_t                sts_o,
  input  logic [VIDX_W-1:0]       vertex_index_i,
  input  logic signed [LAT_W-1:0] point_lat_i,
  input  logic signed [LON_W-1:0] point_lon_i,
  output logic                    inside_res_o
);

  logic signed [LAT_W-1:0]  pt_lat_q, lat_i_q, lat_j_q;
  logic signed [LON_W-1:0]  pt_lon_q, lon_i_q, lon_j_q;
  logic signed [LAT_W-1:0]  rd_lat;
  logic signed [LON_W-1:0]  rd_lon;
  logic [LAT_W+LON_W-1:0]   rdata;
  logic                     we;
  logic signed [DLAT_W-1:0] dlat;
  logic signed [DLON_W-1:0] dlon_pt;
  logic signed [DLON_W-1:0] den;
  logic signed [NUM_W-1:0]  prod;
  logic signed [NUM_W-1:0]  num_q;
  logic signed [DLON_W-1:0] den_q;
  logic [NUM_W-1:0]         num_mag;
  logic [DLON_W-1:0]        den_mag;
  logic [REM_W-1:0]         rem_q;
  logic [QUO_W-1:0]         quo_q;
  logic [REM_W-1:0]         dsr_q;
  logic                     neg_q;
  logic [REM_W:0]           trial;
  logic signed [CMPW-1:0]   q_ext;
  logic signed [CMPW-1:0]   q_signed;
  logic signed [CMPW-1:0]   edge_lat;
  logic                     below;
  logic                     odd_q;
  logic                     res_q;

  assign we = cmd_i.wr && (32'(vertex_index_i) < MAX_VERTICES);

  pip_ram #(
    .WIDTH (LAT_W + LON_W),
    .DEPTH (MAX_VERTICES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (IDX_W'(vertex_index_i)),
    .wdata_i ({point_lat_i, point_lon_i}),
    .raddr_i (cmd_i.raddr),
    .rdata_o (rdata)
  );

  assign rd_lat = rdata[LAT_W+LON_W-1:LON_W];
  assign rd_lon = rdata[LON_W-1:0];

  assign sts_o.straddle = (lon_i_q > pt_lon_q) != (lon_j_q > pt_lon_q);

  assign dlat    = DLAT_W'(lat_j_q) - DLAT_W'(lat_i_q);
  assign dlon_pt = DLON_W'(pt_lon_q) - DLON_W'(lon_i_q);
  assign den     = DLON_W'(lon_j_q) - DLON_W'(lon_i_q);
  assign prod    = dlat * dlon_pt;

  assign num_mag = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
  assign den_mag = den_q[DLON_W-1] ? DLON_W'(-den_q) : DLON_W'(den_q);

  assign trial = {rem_q, quo_q[QUO_W-1]} - {1'b0, dsr_q};

  assign q_ext    = {{(CMPW-QUO_W){1'b0}}, quo_q};
  assign q_signed = neg_q ? -q_ext : q_ext;
  assign edge_lat = q_signed + CMPW'(lat_i_q);
  assign below    = CMPW'(pt_lat_q) < edge_lat;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pt) begin
      pt_lat_q <= point_lat_i;
      pt_lon_q <= point_lon_i;
      odd_q    <= 1'b0;
    end
    if (cmd_i.load_j) begin
      lat_j_q <= rd_lat;
      lon_j_q <= rd_lon;
    end
    if (cmd_i.load_i) begin
      lat_i_q <= rd_lat;
      lon_i_q <= rd_lon;
    end
    if (cmd_i.mul) begin
      num_q <= prod;
      den_q <= den;
    end
    if (cmd_i.prep) begin
      rem_q <= num_mag[NUM_W-1:QUO_W];
      quo_q <= num_mag[QUO_W-1:0];
      dsr_q <= den_mag;
      neg_q <= num_q[NUM_W-1] ^ den_q[DLON_W-1];
    end
    if (cmd_i.div_step) begin
      if (!trial[REM_W]) begin
        rem_q <= trial[REM_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[REM_W-2:0], quo_q[QUO_W-1]};
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
    end
    if (cmd_i.cmp && below) begin
      odd_q <= ~odd_q;
    end
    if (cmd_i.shift) begin
      lat_j_q <= lat_i_q;
      lon_j_q <= lon_i_q;
    end
    if (cmd_i.publish) begin
      res_q <= odd_q;
    end
  end

  assign inside_res_o = res_q;

endmodule

/* sv/pip_ctrl.sv */
// Controller: command decode, vertex count register and the edge-walk sequencer.
module pip_ctrl import pip_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_command_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  pip_sts_t         sts_i,
  output pip_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_J, S_LD_J, S_RD_I, S_LD_I, S_MUL, S_PREP, S_DIV, S_CMP, S_NEXT, S_DONE
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [IDX_W-1:0]  idx_q, last_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;
  logic [CNT_W-1:0]  n_used;
  logic              accept;
  logic              publish;

  assign n_used  = (32'(count_q) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : count_q;
  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign publish = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      last_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && (in_command_i == CMD_TEST)) begin
            idx_q  <= '0;
            last_q <= IDX_W'(n_used - CNT_W'(1));
            state_q <= (n_used < CNT_W'(2)) ? S_DONE : S_RD_J;
          end
        end
        S_RD_J: state_q <= S_LD_J;
        S_LD_J: state_q <= S_RD_I;
        S_RD_I: state_q <= S_LD_I;
        S_LD_I: state_q <= S_MUL;
        S_MUL:  state_q <= sts_i.straddle ? S_PREP : S_NEXT;
        S_PREP: begin
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(QUO_W - 1)) begin
            state_q <= S_CMP;
          end
        end
        S_CMP:  state_q <= S_NEXT;
        S_NEXT: begin
          if (idx_q == last_q) begin
            state_q <= S_DONE;
          end else begin
            idx_q   <= idx_q + IDX_W'(1);
            state_q <= S_RD_I;
          end
        end
        S_DONE: begin
          if (publish) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.wr       = accept && (in_command_i == CMD_WRITE);
    cmd_o.load_pt  = accept && (in_command_i == CMD_TEST);
    cmd_o.load_j   = (state_q == S_LD_J);
    cmd_o.load_i   = (state_q == S_LD_I);
    cmd_o.mul      = (state_q == S_MUL);
    cmd_o.prep     = (state_q == S_PREP);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.cmp      = (state_q == S_CMP);
    cmd_o.shift    = (state_q == S_NEXT);
    cmd_o.publish  = publish;
    cmd_o.raddr    = (state_q == S_RD_J) ? last_q : idx_q;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* sv/point_in_polygon_test.sv */
// Even-odd ray-crossing point-in-polygon test over a table of up to 32 latitude/longitude
// vertices. A write word stores a vertex and gives no result. A test word walks every edge
// of the polygon through one shared multiplier and a 16-step serial divider; an edge whose
// longitude range misses the point's longitude skips the divider. A vertex count below 2
// answers outside without walking any edge. The result sits in an output register, so the
// next word is taken while the result waits. Vertices must be written before they are tested.
module point_in_polygon_test import pip_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  pip_in_if.sink           in_word,
  pip_out_if.source        out_word
);

  pip_cmd_t cmd;
  pip_sts_t sts;
  logic     in_ready;
  logic     out_valid;
  logic     inside_res;

  pip_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_word.valid),
    .in_command_i (in_word.command),
    .in_ready_o   (in_ready),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_word.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  pip_dp u_dp (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .vertex_index_i (in_word.vertex_index),
    .point_lat_i    (in_word.point_lat),
    .point_lon_i    (in_word.point_lon),
    .inside_res_o   (inside_res)
  );

  assign in_word.ready       = in_ready;
  assign out_word.valid      = out_valid;
  assign out_word.inside_res = inside_res;

`ifndef SYNTHESIS
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_word.valid && in_word.ready && (in_word.command == CMD_WRITE) && !out_word.valid)
    |=> !out_word.valid)
    else $error("write word produced a result");

  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_word.valid && in_word.ready && (in_word.command == CMD_TEST)) |=> !in_word.ready)
    else $error("input still ready after a test word was taken");

  a_result_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_word.valid) |-> $past(!in_word.ready))
    else $error("result appeared while the sequencer was idle");
`endif

endmodule
